[hw/rtl/msort_pkg.sv]
`default_nettype none

package msort_pkg;

    // Capacity of one set and the widths that follow from it.
    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = 6;   // indexes MAX_ITEMS entries
    localparam int CNT_W     = 7;   // holds 0 .. MAX_ITEMS
    localparam int DATA_W    = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  wr_en;       // write one memory entry this cycle
        logic  wr_sel;      // 0: bank 0, 1: bank 1
        logic  wr_from_in;  // write data comes from the input stream
        logic  take_a;      // merge winner is the left run head
        addr_t wr_addr;
        logic  rd_en;       // capture read data of both banks
        addr_t rd_addr_a;
        addr_t rd_addr_b;
        logic  src_sel;     // bank that holds the current source runs
        logic  out_load;    // load the output register
        logic  out_last;
        logic  out_ovf;
    } msort_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic a_le_b;       // left head <= right head, signed
        logic out_free;     // output register may be loaded
    } msort_stat_t;

endpackage

`default_nettype wire

[hw/rtl/merge_sort_engine_core.sv]
`default_nettype none

// Channel   Direction  Transaction carries
// s_*       in         one signed value to sort; s_tlast closes the set
// m_*       out        one sorted value; m_tlast ends the run, m_tuser = overflow
//
// A set of n values is first loaded, then merged by one pass per doubling of
// the run width (ceil(log2 n) passes), in which each run is set up and each
// element is read from the source bank and then written to the other bank;
// an emit pass then reads each value and loads it into the output register.
// Each bank has a single read port pair, and every merge step reads, then writes.
// Reset (rst_n, asynchronous, active low) empties the set and the output.
// s_tready is high only while the block collects a set; m_tready low holds
// the result in the output register and pauses the emit pass.

module merge_sort_engine_core
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,    // [31:0] value
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,    // [31:0] sorted_value
    output logic        m_tlast,
    output logic        m_tuser     // [0] overflow
);

    // Commands and status between the sequencer and the memory datapath.
    msort_pkg::msort_cmd_t  cmd;
    msort_pkg::msort_stat_t stat;

    // The controller walks the load, bottom-up merge and emit phases.
    msort_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_last  (s_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

    // The datapath holds the two ping-pong banks, the comparator and the
    // output register.
    msort_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_value  (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata),
        .out_last  (m_tlast),
        .out_ovf   (m_tuser)
    );

endmodule

`default_nettype wire

[hw/rtl/msort_datapath.sv]
`default_nettype none

module msort_datapath
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  msort_pkg::msort_cmd_t    cmd,
    output msort_pkg::msort_stat_t   stat,
    input  wire  [31:0]              in_value,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic [31:0]              out_value,
    output logic                     out_last,
    output logic                     out_ovf
);

    // Two banks used in ping-pong fashion: each merge pass reads one and
    // writes the other.
    msort_pkg::data_t bank0 [msort_pkg::MAX_ITEMS];
    msort_pkg::data_t bank1 [msort_pkg::MAX_ITEMS];

    msort_pkg::data_t rd0a_reg;
    msort_pkg::data_t rd0b_reg;
    msort_pkg::data_t rd1a_reg;
    msort_pkg::data_t rd1b_reg;
    msort_pkg::data_t rd_a;
    msort_pkg::data_t rd_b;
    msort_pkg::data_t wr_data;

    logic             out_valid_reg;
    msort_pkg::data_t out_value_reg;
    logic             out_last_reg;
    logic             out_ovf_reg;

    always_comb
    begin
        rd_a    = cmd.src_sel ? rd1a_reg : rd0a_reg;
        rd_b    = cmd.src_sel ? rd1b_reg : rd0b_reg;
        wr_data = cmd.wr_from_in ? in_value : (cmd.take_a ? rd_a : rd_b);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && !cmd.wr_sel)
        begin
            bank0[cmd.wr_addr] <= wr_data;
        end
        if (cmd.wr_en && cmd.wr_sel)
        begin
            bank1[cmd.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd0a_reg <= bank0[cmd.rd_addr_a];
            rd0b_reg <= bank0[cmd.rd_addr_b];
            rd1a_reg <= bank1[cmd.rd_addr_a];
            rd1b_reg <= bank1[cmd.rd_addr_b];
        end
    end

    assign stat.a_le_b   = $signed(rd_a) <= $signed(rd_b);
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg <= rd_a;
            out_last_reg  <= cmd.out_last;
            out_ovf_reg   <= cmd.out_ovf;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;

endmodule

`default_nettype wire

[hw/rtl/msort_ctrl.sv]
`default_nettype none

module msort_ctrl
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire                      in_last,
    output msort_pkg::msort_cmd_t    cmd,
    input  msort_pkg::msort_stat_t   stat
);

    typedef enum logic [6:0] {
        S_LOAD    = 7'b0000001,
        S_PASS    = 7'b0000010,
        S_RUN     = 7'b0000100,
        S_RD      = 7'b0001000,
        S_WR      = 7'b0010000,
        S_EMIT_RD = 7'b0100000,
        S_EMIT_WR = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    msort_pkg::cnt_t   count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic              src_reg, src_next;
    msort_pkg::cnt_t   width_reg, width_next;
    msort_pkg::cnt_t   lo_reg, lo_next;
    msort_pkg::cnt_t   mid_reg, mid_next;
    msort_pkg::cnt_t   hi_reg, hi_next;
    msort_pkg::cnt_t   a_reg, a_next;
    msort_pkg::cnt_t   b_reg, b_next;
    msort_pkg::cnt_t   k_reg, k_next;

    logic [msort_pkg::CNT_W:0] mid_sum;
    logic [msort_pkg::CNT_W:0] hi_sum;
    logic                      accept;
    logic                      a_avail;
    logic                      b_avail;
    logic                      take_a;
    msort_pkg::cnt_t           k_inc;

    always_comb
    begin
        accept  = in_valid && in_ready;
        mid_sum = {1'b0, lo_reg} + {1'b0, width_reg};
        hi_sum  = mid_sum + {1'b0, width_reg};
        a_avail = a_reg < mid_reg;
        b_avail = b_reg < hi_reg;
        take_a  = a_avail && (!b_avail || stat.a_le_b);
        k_inc   = k_reg + msort_pkg::cnt_t'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        src_next   = src_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        in_ready   = 1'b0;

        cmd            = '0;
        cmd.src_sel    = src_reg;
        cmd.take_a     = take_a;
        cmd.wr_addr    = k_reg[msort_pkg::ADDR_W-1:0];
        cmd.wr_sel     = !src_reg;
        cmd.rd_addr_a  = a_reg[msort_pkg::ADDR_W-1:0];
        cmd.rd_addr_b  = b_reg[msort_pkg::ADDR_W-1:0];

        case (state_reg)
            S_LOAD:
            begin
                in_ready       = 1'b1;
                cmd.wr_from_in = 1'b1;
                cmd.wr_sel     = 1'b0;
                cmd.wr_addr    = count_reg[msort_pkg::ADDR_W-1:0];
                if (accept)
                begin
                    if (count_reg < msort_pkg::cnt_t'(msort_pkg::MAX_ITEMS))
                    begin
                        cmd.wr_en  = 1'b1;
                        count_next = count_reg + msort_pkg::cnt_t'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        width_next = msort_pkg::cnt_t'(1);
                        src_next   = 1'b0;
                        state_next = S_PASS;
                    end
                end
            end

            S_PASS:
            begin
                if (width_reg < count_reg)
                begin
                    lo_next    = '0;
                    state_next = S_RUN;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_EMIT_RD;
                end
            end

            S_RUN:
            begin
                if (lo_reg < count_reg)
                begin
                    mid_next = (mid_sum > {1'b0, count_reg}) ? count_reg
                                                             : mid_sum[msort_pkg::CNT_W-1:0];
                    hi_next  = (hi_sum > {1'b0, count_reg}) ? count_reg
                                                            : hi_sum[msort_pkg::CNT_W-1:0];
                    a_next   = lo_reg;
                    b_next   = (mid_sum > {1'b0, count_reg}) ? count_reg
                                                             : mid_sum[msort_pkg::CNT_W-1:0];
                    k_next   = lo_reg;
                    state_next = S_RD;
                end
                else
                begin
                    src_next   = !src_reg;
                    width_next = {width_reg[msort_pkg::CNT_W-2:0], 1'b0};
                    state_next = S_PASS;
                end
            end

            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_WR;
            end

            S_WR:
            begin
                cmd.wr_en = 1'b1;
                if (take_a)
                begin
                    a_next = a_reg + msort_pkg::cnt_t'(1);
                end
                else
                begin
                    b_next = b_reg + msort_pkg::cnt_t'(1);
                end
                k_next = k_inc;
                if (k_inc == hi_reg)
                begin
                    lo_next    = hi_reg;
                    state_next = S_RUN;
                end
                else
                begin
                    state_next = S_RD;
                end
            end

            S_EMIT_RD:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_addr_a = k_reg[msort_pkg::ADDR_W-1:0];
                state_next    = S_EMIT_WR;
            end

            S_EMIT_WR:
            begin
                cmd.out_last = k_inc == count_reg;
                cmd.out_ovf  = ovf_reg;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    k_next       = k_inc;
                    if (k_inc == count_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            src_reg   <= 1'b0;
            width_reg <= '0;
            lo_reg    <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            src_reg   <= src_next;
            width_reg <= width_next;
            lo_reg    <= lo_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            k_reg     <= k_next;
        end
    end

endmodule

`default_nettype wire
